FILE: sv/sqb_pkg.sv
// shared types and constants of the sprite quad batcher
package sqb_pkg;

   localparam logic [1:0] OP_BEGIN = 2'd0;
   localparam logic [1:0] OP_DRAW  = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   localparam logic [1:0] KIND_VERTEX = 2'd0;
   localparam logic [1:0] KIND_INDEX  = 2'd1;
   localparam logic [1:0] KIND_RANGE  = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   localparam logic [1:0] ERR_BEGIN = 2'd0;
   localparam logic [1:0] ERR_DRAW  = 2'd1;
   localparam logic [1:0] ERR_END   = 2'd2;

   localparam logic [13:0] LIMIT_CAP   = 14'd8192;
   localparam logic [13:0] LIMIT_RESET = 14'd8192;

   typedef struct packed {
      logic [1:0]         operation;
      logic [15:0]        size_x;
      logic [15:0]        size_y;
      logic signed [15:0] scale_x;
      logic signed [15:0] scale_y;
      logic [15:0]        angle;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic [15:0]        texture;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [23:0] vx;
      logic signed [23:0] vy;
      logic               tex_u;
      logic               tex_v;
      logic [14:0]        slot;
      logic [15:0]        range_texture;
      logic [12:0]        range_first;
      logic [13:0]        range_count;
      logic [15:0]        draw_calls;
      logic [1:0]         error_code;
      logic               last;
   } rsp_type;

   // classified job handed from front to back
   typedef struct packed {
      logic               pre_range;   // range ahead of the sprite (full or texture change) or at end of batch
      logic               sprite;      // vertices and indices follow
      logic               err;
      logic [1:0]         err_code;
      logic [15:0]        range_texture;
      logic [12:0]        range_first;
      logic [13:0]        range_count;
      logic [15:0]        draw_calls;
      logic [12:0]        sprite_index;
      logic [14:0]        half_x;
      logic [14:0]        half_y;
      logic signed [15:0] scale_x;
      logic signed [15:0] scale_y;
      logic [15:0]        angle;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
   } job_type;

endpackage

FILE: sv/sqb_front.sv
// front end: batch state, classification of requests into jobs
module sqb_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [13:0]     csr_data,
   input  logic            req_valid,
   output logic            req_ready,
   input  sqb_pkg::req_type req_data,
   output logic            job_valid,
   input  logic            job_ready,
   output sqb_pkg::job_type job_data
);
   logic [13:0] limit_ff, limit_in;
   logic        drawing_ff, drawing_in;
   logic [13:0] count_ff, count_in;
   logic [12:0] start_ff, start_in;
   logic [15:0] rtex_ff, rtex_in;
   logic [15:0] calls_ff, calls_in;
   logic [13:0] lim;
   logic [13:0] cnt;
   logic [12:0] st;
   logic        full, change;
   logic [15:0] calls_inc;
   sqb_pkg::job_type j;
   logic        emit;

   assign req_ready = job_ready;
   assign calls_inc = (calls_ff == 16'hFFFF) ? calls_ff : calls_ff + 16'd1;

   always_comb begin
      lim = limit_ff;
      if (lim > sqb_pkg::LIMIT_CAP) lim = sqb_pkg::LIMIT_CAP;
      if (lim == 14'd0) lim = 14'd1;
   end

   always_comb begin
      drawing_in = drawing_ff;
      count_in   = count_ff;
      start_in   = start_ff;
      rtex_in    = rtex_ff;
      calls_in   = calls_ff;
      limit_in   = csr_we ? csr_data : limit_ff;
      j          = '0;
      emit       = 1'b0;
      full       = 1'b0;
      change     = 1'b0;
      cnt        = count_ff;
      st         = start_ff;
      j.half_x   = req_data.size_x[15:1];
      j.half_y   = req_data.size_y[15:1];
      j.scale_x  = req_data.scale_x;
      j.scale_y  = req_data.scale_y;
      j.angle    = req_data.angle;
      j.pos_x    = req_data.pos_x;
      j.pos_y    = req_data.pos_y;
      j.range_texture = rtex_ff;
      j.range_first   = start_ff;
      j.range_count   = count_ff - {1'b0, start_ff};
      j.draw_calls    = calls_inc;
      unique case (req_data.operation)
         sqb_pkg::OP_BEGIN: begin
            if (drawing_ff) begin
               emit = 1'b1;
               j.err = 1'b1;
               j.err_code = sqb_pkg::ERR_BEGIN;
            end else begin
               drawing_in = 1'b1;
               count_in = '0;
               start_in = '0;
               calls_in = '0;
            end
         end
         sqb_pkg::OP_DRAW: begin
            emit = 1'b1;
            if (!drawing_ff) begin
               j.err = 1'b1;
               j.err_code = sqb_pkg::ERR_DRAW;
            end else begin
               j.sprite = 1'b1;
               full = count_ff >= lim;
               if (full) begin
                  cnt = '0;
                  st = '0;
               end
               if (cnt == 14'd0) begin
                  st = '0;
               end else if (req_data.texture != rtex_ff) begin
                  change = 1'b1;
                  st = cnt[12:0];
               end
               j.pre_range = full | change;
               if (full | change) calls_in = calls_inc;
               rtex_in = req_data.texture;
               start_in = st;
               j.sprite_index = cnt[12:0];
               count_in = cnt + 14'd1;
            end
         end
         sqb_pkg::OP_END: begin
            if (!drawing_ff) begin
               emit = 1'b1;
               j.err = 1'b1;
               j.err_code = sqb_pkg::ERR_END;
            end else begin
               drawing_in = 1'b0;
               if (count_ff != 14'd0) begin
                  emit = 1'b1;
                  j.pre_range = 1'b1;
                  calls_in = calls_inc;
               end
               count_in = '0;
               start_in = '0;
            end
         end
         default: ;
      endcase
   end

   logic acc;
   assign acc = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= sqb_pkg::LIMIT_RESET;
         drawing_ff <= 1'b0;
         count_ff   <= '0;
         start_ff   <= '0;
         rtex_ff    <= '0;
         calls_ff   <= '0;
      end else begin
         limit_ff <= limit_in;
         if (acc) begin
            drawing_ff <= drawing_in;
            count_ff   <= count_in;
            start_ff   <= start_in;
            rtex_ff    <= rtex_in;
            calls_ff   <= calls_in;
         end
      end
   end

   assign job_valid = acc & emit;
   assign job_data  = j;
endmodule

FILE: sv/sqb_queue.sv
// two-entry job queue between front and back
module sqb_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  sqb_pkg::job_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output sqb_pkg::job_type out_data
);
   sqb_pkg::job_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] fill_ff;
   logic       push, pop;

   assign in_ready  = fill_ff != 2'd2;
   assign out_valid = fill_ff != 2'd0;
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid & in_ready;
   assign pop  = out_valid & out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         fill_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

FILE: sv/sqb_back.sv
// back end: sine/cosine, corner transform and result sequencing
module sqb_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            job_valid,
   output logic            job_ready,
   input  sqb_pkg::job_type job_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output sqb_pkg::rsp_type rsp_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_RANGE, S_SIN1, S_SIN2, S_SIN3, S_SIN4, S_SIN5,
      S_MULA, S_MULB, S_SUM, S_VTX, S_IDX
   } state_type;

   state_type        state_ff;
   sqb_pkg::job_type job_ff;
   logic             sel_ff;    // 0 sine, 1 cosine pass
   logic [14:0]      f_ff;
   logic             neg_ff;
   logic [31:0]      z2_ff, t_ff;
   logic signed [16:0] sin_ff, cos_ff;
   logic [1:0]       corner_ff;
   logic [2:0]       idx_ff;
   logic signed [31:0] sx_ff, sy_ff;
   logic signed [48:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [23:0] vx_ff, vy_ff;
   logic             busy_out_ff;
   sqb_pkg::rsp_type out_ff;

   logic [15:0] ang;
   logic [1:0]  q;
   logic [13:0] fr;
   logic [14:0] f_in;
   logic [31:0] prod;
   logic [31:0] s_raw;
   logic [15:0] s_clip;
   logic        right, bottom;
   logic signed [15:0] hx, hy;
   logic signed [50:0] ax, ay, rx, ry;
   logic [14:0] base;
   logic [1:0]  off;
   logic        can_out;
   logic        out_load;

   function automatic logic signed [23:0] sat_round(input logic signed [50:0] v);
      logic signed [50:0] r;
      r = (v + 51'sd16384) >>> 15;
      if (r > 51'sd8388607) return 24'sh7FFFFF;
      if (r < -51'sd8388608) return 24'sh800000;
      return r[23:0];
   endfunction

   assign can_out = !busy_out_ff || rsp_ready;
   assign ang  = sel_ff ? job_ff.angle + 16'd16384 : job_ff.angle;
   assign q    = ang[15:14];
   assign fr   = ang[13:0];
   assign f_in = q[0] ? 15'd16384 - {1'b0, fr} : {1'b0, fr};
   assign base = {job_ff.sprite_index, 2'b00};
   assign right  = corner_ff == 2'd1 || corner_ff == 2'd2;
   assign bottom = corner_ff[1];
   assign hx = right  ? $signed({1'b0, job_ff.half_x}) : -$signed({1'b0, job_ff.half_x});
   assign hy = bottom ? $signed({1'b0, job_ff.half_y}) : -$signed({1'b0, job_ff.half_y});

   // one multiplier walks the polynomial, one product per state
   always_comb begin
      prod = '0;
      unique case (state_ff)
         S_SIN2: prod = 32'({17'd0, f_ff}) * 32'({17'd0, f_ff});
         S_SIN3: prod = 32'd2320 * z2_ff;
         S_SIN4: prod = (32'd21024 - t_ff) * z2_ff;
         S_SIN5: prod = (32'd51472 - t_ff) * 32'({17'd0, f_ff});
         default: prod = '0;
      endcase
      s_raw  = prod >> 14;
      s_clip = (s_raw > 32'd32767) ? 16'd32767 : s_raw[15:0];
   end

   always_comb begin
      ax = 51'(p1_ff) - 51'(p2_ff) + 51'(job_ff.pos_x) * 51'sd32768;
      ay = 51'(p3_ff) + 51'(p4_ff) + 51'(job_ff.pos_y) * 51'sd32768;
      rx = ax;
      ry = ay;
      unique case (idx_ff)
         3'd0: off = 2'd0;
         3'd1: off = 2'd1;
         3'd2: off = 2'd3;
         3'd3: off = 2'd3;
         3'd4: off = 2'd1;
         3'd5: off = 2'd2;
         default: off = 2'd0;
      endcase
   end

   assign out_load = can_out && ((state_ff == S_IDLE && job_valid && job_data.err)
                     || state_ff == S_RANGE || state_ff == S_VTX || state_ff == S_IDX);

   assign job_ready = state_ff == S_IDLE && can_out;
   assign rsp_valid = busy_out_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_out_ff <= 1'b0;
      end else begin
         if (out_load) busy_out_ff <= 1'b1;
         else if (rsp_ready) busy_out_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (job_valid && can_out) begin
                  job_ff <= job_data;
                  sel_ff <= 1'b0;
                  corner_ff <= '0;
                  idx_ff <= '0;
                  if (job_data.err) begin
                     out_ff <= '0;
                     out_ff.kind <= sqb_pkg::KIND_ERROR;
                     out_ff.error_code <= job_data.err_code;
                     out_ff.last <= 1'b1;
                  end else if (job_data.pre_range) begin
                     state_ff <= S_RANGE;
                  end else begin
                     state_ff <= S_SIN1;
                  end
               end
            end
            S_RANGE: begin
               if (can_out) begin
                  out_ff <= '0;
                  out_ff.kind <= sqb_pkg::KIND_RANGE;
                  out_ff.range_texture <= job_ff.range_texture;
                  out_ff.range_first <= job_ff.range_first;
                  out_ff.range_count <= job_ff.range_count;
                  out_ff.draw_calls <= job_ff.draw_calls;
                  out_ff.last <= !job_ff.sprite;
                  state_ff <= job_ff.sprite ? S_SIN1 : S_IDLE;
               end
            end
            S_SIN1: begin
               f_ff <= f_in;
               neg_ff <= q[1];
               state_ff <= S_SIN2;
            end
            S_SIN2: begin
               z2_ff <= prod >> 14;
               state_ff <= S_SIN3;
            end
            S_SIN3: begin
               t_ff <= prod >> 14;
               state_ff <= S_SIN4;
            end
            S_SIN4: begin
               t_ff <= prod >> 14;
               state_ff <= S_SIN5;
            end
            S_SIN5: begin
               if (sel_ff) begin
                  cos_ff <= neg_ff ? -$signed({1'b0, s_clip}) : $signed({1'b0, s_clip});
                  state_ff <= S_MULA;
               end else begin
                  sin_ff <= neg_ff ? -$signed({1'b0, s_clip}) : $signed({1'b0, s_clip});
                  sel_ff <= 1'b1;
                  state_ff <= S_SIN1;
               end
            end
            S_MULA: begin
               sx_ff <= 32'(hx) * 32'(job_ff.scale_x);
               sy_ff <= 32'(hy) * 32'(job_ff.scale_y);
               state_ff <= S_MULB;
            end
            S_MULB: begin
               p1_ff <= 49'(sx_ff) * 49'(cos_ff);
               p2_ff <= 49'(sy_ff) * 49'(sin_ff);
               p3_ff <= 49'(sx_ff) * 49'(sin_ff);
               p4_ff <= 49'(sy_ff) * 49'(cos_ff);
               state_ff <= S_SUM;
            end
            S_SUM: begin
               vx_ff <= sat_round(rx);
               vy_ff <= sat_round(ry);
               state_ff <= S_VTX;
            end
            S_VTX: begin
               if (can_out) begin
                  out_ff <= '0;
                  out_ff.kind <= sqb_pkg::KIND_VERTEX;
                  out_ff.vx <= vx_ff;
                  out_ff.vy <= vy_ff;
                  out_ff.tex_u <= right;
                  out_ff.tex_v <= bottom;
                  out_ff.slot <= base + {13'd0, corner_ff};
                  corner_ff <= corner_ff + 2'd1;
                  state_ff <= (corner_ff == 2'd3) ? S_IDX : S_MULA;
               end
            end
            S_IDX: begin
               if (can_out) begin
                  out_ff <= '0;
                  out_ff.kind <= sqb_pkg::KIND_INDEX;
                  out_ff.slot <= base + {13'd0, off};
                  out_ff.last <= idx_ff == 3'd5;
                  idx_ff <= idx_ff + 3'd1;
                  if (idx_ff == 3'd5) state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

FILE: sv/sprite_quad_batcher.sv
// top level of the sprite quad batcher
//
// requests arrive on req_valid/req_ready with a req_data struct: begin,
// draw sprite, end or no-op. results leave on rsp_valid/rsp_ready as rsp_data:
// vertices, index entries, draw ranges and errors, the last result of each
// request flagged by last. csr_we writes batch_limit from csr_data at once.
// the front end keeps batch state and classifies each request combinationally;
// a two-entry job queue feeds the back end, which runs the sine and cosine
// on one shared multiplier (states S_SIN1 to S_SIN5, once for each), then per
// corner scales, rotates and rounds before presenting the vertex. a sprite
// yields ten results, or eleven with a range ahead of it; a range or error
// job gives one result. a begin, an empty end or a no-op gives no result.
// reset clears the batch state, empties the queue and the output register
// and sets batch_limit to 8192. when the receiver stalls the output register
// holds, the back end waits, and once the queue is full req_ready drops.
module sprite_quad_batcher (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [13:0]      csr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  sqb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sqb_pkg::rsp_type rsp_data
);
   logic fj_valid, fj_ready, bj_valid, bj_ready;
   sqb_pkg::job_type fj_data, bj_data;

   sqb_front u_front (
      .clock, .reset, .csr_we, .csr_data, .req_valid, .req_ready, .req_data,
      .job_valid(fj_valid), .job_ready(fj_ready), .job_data(fj_data)
   );

   sqb_queue u_queue (
      .clock, .reset,
      .in_valid(fj_valid), .in_ready(fj_ready), .in_data(fj_data),
      .out_valid(bj_valid), .out_ready(bj_ready), .out_data(bj_data)
   );

   sqb_back u_back (
      .clock, .reset,
      .job_valid(bj_valid), .job_ready(bj_ready), .job_data(bj_data),
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule

FILE: sim/sprite_quad_batcher_tb.sv
// self-checking testbench of the sprite quad batcher
`timescale 1ns / 1ps

module sprite_quad_batcher_tb;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_we = 1'b0;
   logic [13:0] csr_data = '0;
   logic    req_valid = 1'b0;
   logic    req_ready;
   sqb_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   sqb_pkg::rsp_type rsp_data;

   sprite_quad_batcher DUT (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // predictor state
   logic [13:0] limit_reg;
   logic        drawing;
   int unsigned sprite_count, run_start, run_texture, call_count;

   sqb_pkg::req_type pending_reqs[$];
   sqb_pkg::rsp_type expected_rsps[$];
   int      failures = 0;
   int      cycles = 0;
   int      hold_off = 0;
   bit      burst_on = 1'b0;
   int      burst_left = 0;

   function automatic int sine_q15(input logic [15:0] a);
      int unsigned q, f, z2, t, s;
      q = 32'(a[15:14]);
      f = 32'(a[13:0]);
      if (q[0]) f = 16384 - f;
      z2 = (f * f) >> 14;
      t = (2320 * z2) >> 14;
      t = 21024 - t;
      t = (t * z2) >> 14;
      t = 51472 - t;
      s = (t * f) >> 14;
      if (s > 32767) s = 32767;
      return (q >= 2) ? -int'(s) : int'(s);
   endfunction

   function automatic logic signed [23:0] round_q16_8(input longint v);
      longint r;
      r = (v + 16384) >>> 15;
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      return r[23:0];
   endfunction

   task automatic queue_rsp(input sqb_pkg::rsp_type r);
      expected_rsps = {expected_rsps, r};
   endtask

   task automatic queue_req(input sqb_pkg::req_type r);
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic push_range();
      sqb_pkg::rsp_type r;
      r = '0;
      r.kind = sqb_pkg::KIND_RANGE;
      if (call_count < 65535) call_count++;
      r.range_texture = run_texture[15:0];
      r.range_first = run_start[12:0];
      r.range_count = 14'(sprite_count - run_start);
      r.draw_calls = call_count[15:0];
      queue_rsp(r);
   endtask

   task automatic push_error(input logic [1:0] code);
      sqb_pkg::rsp_type r;
      r = '0;
      r.kind = sqb_pkg::KIND_ERROR;
      r.error_code = code;
      queue_rsp(r);
   endtask

   // works out the results of one accepted request
   task automatic predict_batcher(input sqb_pkg::req_type q);
      int          n0, i;
      int unsigned lim, base;
      longint      hw, hh, sx, sy, s, c, px, py;
      sqb_pkg::rsp_type r;
      int          offs[6];
      offs = '{0, 1, 3, 3, 1, 2};
      n0 = expected_rsps.size();
      case (q.operation)
         sqb_pkg::OP_BEGIN: begin
            if (drawing) push_error(sqb_pkg::ERR_BEGIN);
            else begin
               drawing = 1'b1; sprite_count = 0; run_start = 0; call_count = 0;
            end
         end
         sqb_pkg::OP_DRAW: begin
            if (!drawing) push_error(sqb_pkg::ERR_DRAW);
            else begin
               lim = 32'(limit_reg);
               if (lim > 8192) lim = 8192;
               if (lim < 1) lim = 1;
               if (sprite_count >= lim) begin
                  push_range(); sprite_count = 0; run_start = 0;
               end
               if (sprite_count == 0) begin
                  run_start = 0; run_texture = 32'(q.texture);
               end else if (q.texture != run_texture) begin
                  push_range(); run_start = sprite_count; run_texture = 32'(q.texture);
               end
               hw = longint'(q.size_x >> 1); hh = longint'(q.size_y >> 1);
               s = longint'(sine_q15(q.angle));
               c = longint'(sine_q15(q.angle + 16'd16384));
               px = longint'(q.pos_x); py = longint'(q.pos_y);
               base = sprite_count * 4;
               for (i = 0; i < 4; i++) begin
                  sx = ((i == 1 || i == 2) ? hw : -hw) * longint'(q.scale_x);
                  sy = ((i >= 2) ? hh : -hh) * longint'(q.scale_y);
                  r = '0;
                  r.kind = sqb_pkg::KIND_VERTEX;
                  r.vx = round_q16_8(sx * c - sy * s + px * 32768);
                  r.vy = round_q16_8(sx * s + sy * c + py * 32768);
                  r.tex_u = (i == 1 || i == 2);
                  r.tex_v = (i >= 2);
                  r.slot = 15'(base + i);
                  queue_rsp(r);
               end
               for (i = 0; i < 6; i++) begin
                  r = '0;
                  r.kind = sqb_pkg::KIND_INDEX;
                  r.slot = 15'(base + offs[i]);
                  queue_rsp(r);
               end
               sprite_count++;
            end
         end
         sqb_pkg::OP_END: begin
            if (!drawing) push_error(sqb_pkg::ERR_END);
            else begin
               drawing = 1'b0;
               if (sprite_count > 0) push_range();
               sprite_count = 0; run_start = 0;
            end
         end
         default: ;
      endcase
      if (expected_rsps.size() > n0) expected_rsps[$].last = 1'b1;
   endtask

   // driver: bursts with random gaps
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) predict_batcher(req_data);
         if (!req_valid || req_ready) begin
            if (burst_left == 0) begin
               burst_on <= ~burst_on;
               burst_left <= burst_on ? $urandom_range(1, 12) : $urandom_range(0, 6);
               req_valid <= 1'b0;
            end else begin
               burst_left <= burst_left - 1;
               if (burst_on && pending_reqs.size() > 0) begin
                  req_data <= pending_reqs.pop_front();
                  req_valid <= 1'b1;
               end else
                  req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, with a long hold-off early on and now and then
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else if (cycles == 200 || $urandom_range(0, 499) == 0) begin
         hold_off <= 400;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= (cycles[9:8] == 2'd1) ? 1'b1 : ($urandom_range(0, 3) != 0);
   end

   // monitor
   always @(posedge clock) begin
      sqb_pkg::rsp_type e;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result kind=%0d", rsp_data.kind);
            failures++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.kind !== e.kind) begin
               $error("kind exp %0d got %0d", e.kind, rsp_data.kind); failures++; end
            if (rsp_data.vx !== e.vx) begin
               $error("vx exp %0d got %0d", e.vx, rsp_data.vx); failures++; end
            if (rsp_data.vy !== e.vy) begin
               $error("vy exp %0d got %0d", e.vy, rsp_data.vy); failures++; end
            if (rsp_data.tex_u !== e.tex_u) begin
               $error("tex_u exp %0d got %0d", e.tex_u, rsp_data.tex_u); failures++; end
            if (rsp_data.tex_v !== e.tex_v) begin
               $error("tex_v exp %0d got %0d", e.tex_v, rsp_data.tex_v); failures++; end
            if (rsp_data.slot !== e.slot) begin
               $error("slot exp %0d got %0d", e.slot, rsp_data.slot); failures++; end
            if (rsp_data.range_texture !== e.range_texture) begin
               $error("range_texture exp %0d got %0d", e.range_texture,
                      rsp_data.range_texture); failures++; end
            if (rsp_data.range_first !== e.range_first) begin
               $error("range_first exp %0d got %0d", e.range_first,
                      rsp_data.range_first); failures++; end
            if (rsp_data.range_count !== e.range_count) begin
               $error("range_count exp %0d got %0d", e.range_count,
                      rsp_data.range_count); failures++; end
            if (rsp_data.draw_calls !== e.draw_calls) begin
               $error("draw_calls exp %0d got %0d", e.draw_calls,
                      rsp_data.draw_calls); failures++; end
            if (rsp_data.error_code !== e.error_code) begin
               $error("error_code exp %0d got %0d", e.error_code,
                      rsp_data.error_code); failures++; end
            if (rsp_data.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_data.last); failures++; end
         end
      end
      if (cycles > 600000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic sqb_pkg::req_type make_req(input logic [1:0] op,
                                                 input logic [15:0] tex);
      sqb_pkg::req_type q;
      q = '0;
      q.operation = op;
      q.size_x = 16'($urandom); q.size_y = 16'($urandom);
      q.scale_x = 16'($urandom); q.scale_y = 16'($urandom);
      q.angle = 16'($urandom);
      q.pos_x = 24'($urandom); q.pos_y = 24'($urandom);
      q.texture = tex;
      if ($urandom_range(0, 2) == 0) begin
         // modest sizes so that vertices stay clear of saturation
         q.size_x = 16'($urandom_range(0, 255)); q.size_y = 16'($urandom_range(0, 255));
         q.scale_x = 16'($urandom_range(0, 1023) - 512);
         q.scale_y = 16'($urandom_range(0, 1023) - 512);
         q.pos_x = 24'($urandom_range(0, 65535) - 32768);
         q.pos_y = 24'($urandom_range(0, 65535) - 32768);
      end
      return q;
   endfunction

   // waits for the block to drain before a register write
   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_limit(input logic [13:0] v);
      wait_idle();
      csr_data <= v;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      limit_reg = v;
   endtask

   task automatic random_phase(input int count);
      int k, j, len;
      logic [15:0] tex;
      k = 0;
      while (k < count) begin
         if ($urandom_range(0, 5) == 0) begin
            queue_req(make_req(2'($urandom_range(0, 3)), 16'($urandom)));
            k++;
         end else begin
            queue_req(make_req(sqb_pkg::OP_BEGIN, 16'd0));
            len = $urandom_range(1, 9);
            tex = 16'($urandom_range(0, 2));
            for (j = 0; j < len; j++) begin
               if ($urandom_range(0, 2) == 0) tex = 16'($urandom_range(0, 2));
               if ($urandom_range(0, 20) == 0) tex = 16'($urandom);
               queue_req(make_req(sqb_pkg::OP_DRAW, tex));
            end
            queue_req(make_req(sqb_pkg::OP_END, 16'd0));
            k += len + 2;
         end
      end
   endtask

   initial begin
      sqb_pkg::req_type q;
      limit_reg = sqb_pkg::LIMIT_RESET;
      drawing = 1'b0;
      sprite_count = 0; run_start = 0; run_texture = 0; call_count = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: errors while idle, double begin, empty batch, unused operation, extremes
      queue_req(make_req(sqb_pkg::OP_DRAW, 16'd0));
      queue_req(make_req(sqb_pkg::OP_END, 16'd0));
      queue_req(make_req(sqb_pkg::OP_NOP, 16'd0));
      queue_req(make_req(sqb_pkg::OP_BEGIN, 16'd0));
      queue_req(make_req(sqb_pkg::OP_END, 16'd0));
      queue_req(make_req(sqb_pkg::OP_BEGIN, 16'd0));
      queue_req(make_req(sqb_pkg::OP_BEGIN, 16'd0));
      q = '0; q.operation = sqb_pkg::OP_DRAW; q.size_x = 16'hFFFF; q.size_y = 16'hFFFF;
      q.scale_x = 16'sh7FFF; q.scale_y = 16'sh8000; q.angle = 16'h0000;
      q.pos_x = 24'sh7FFFFF; q.pos_y = 24'sh800000; q.texture = 16'hFFFF;
      queue_req(q);
      q.angle = 16'h4000; q.scale_x = 16'sh8000; q.scale_y = 16'sh7FFF;
      q.pos_x = 24'sh800000; q.pos_y = 24'sh7FFFFF;
      queue_req(q);
      q.angle = 16'hFFFF; q.texture = 16'h0000; q.size_x = 16'd0; q.size_y = 16'd1;
      queue_req(q);
      q.angle = 16'h8000; q.size_x = 16'd100; q.size_y = 16'd3;
      q.scale_x = 16'sh0100; q.scale_y = 16'sh0100; q.pos_x = 24'sd0; q.pos_y = 24'sd0;
      queue_req(q);
      q.angle = 16'hC000; queue_req(q);
      q.angle = 16'h2000; queue_req(q);
      queue_req(make_req(sqb_pkg::OP_END, 16'd0));
      random_phase(45);

      // batch limit of one forces a flush before every sprite but the first of a batch
      write_limit(14'd1);
      random_phase(30);
      write_limit(14'd0);
      random_phase(20);
      write_limit(14'd3);
      random_phase(40);
      write_limit(14'h3FFF);
      random_phase(25);
      write_limit(14'd8192);
      random_phase(20);

      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
sv/sqb_pkg.sv
sv/sqb_front.sv
sv/sqb_queue.sv
sv/sqb_back.sv
sv/sprite_quad_batcher.sv
sim/sprite_quad_batcher_tb.sv
